// ===== sv/bier_ipv6_replicator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// BIER IPv6 replicator assertion macros
// Shared property forms for the replicator checks, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BIER_IPV6_REPLICATOR_UNIT_DEFINES_SVH
`define BIER_IPV6_REPLICATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BIERREP_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BIERREP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bierrep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BIER IPv6 replicator package
// Table size, field widths, codes and the command and status bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
package bierrep_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = IDX_W + 1;

	localparam int ENTRY_IDX_W = 4;
	localparam int HALF_W = 64;
	localparam int HOP_W = 8;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_FWD = 1'b1;

	localparam logic [HOP_W-1:0] HOP_MIN_FWD = 8'd2;

	typedef enum logic [1:0] {
		KIND_REPLICA = 2'd0,
		KIND_HOP_EXCEEDED = 2'd1,
		KIND_NO_REPLICA = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [HALF_W-1:0] addr_hi;
		logic [HALF_W-1:0] addr_lo;
		logic [HALF_W-1:0] mask_hi;
		logic [HALF_W-1:0] mask_lo;
	} entry_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [ENTRY_IDX_W-1:0] egress;
		logic [HALF_W-1:0] addr_hi;
		logic [HALF_W-1:0] addr_lo;
		logic [HOP_W-1:0] hop;
		logic last;
	} res_t;

	typedef struct packed {
		logic wr;
		logic load;
		logic hop_exc;
		logic issue;
		logic [IDX_W-1:0] idx;
		logic final_res;
	} dp_cmd_t;

	typedef struct packed {
		logic s1_vld;
		logic stall;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== sv/bier_ipv6_replicator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BIER IPv6 replicator
// Table-driven replication of IPv6 packets by a bit string in the
// destination address.
// ----------------------------------------------------------------------------
// A write word (mode 0) loads one table slot. A packet word (mode 1) is
// compared against the table one slot per cycle from a single read port,
// except while the scan stalls on a full output register, and it holds the
// input until its final word is loaded into the output register; a packet
// whose hop limit is 1 or less skips the scan and gives a single hop-exceeded
// word. Replicas come out in slot order with last set on the final word, and
// a packet with no qualifying slot gives a single no-replica word.
module bier_ipv6_replicator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [bierrep_pkg::ENTRY_IDX_W-1:0] entry_index,
	input  logic [bierrep_pkg::HALF_W-1:0] addr_hi,
	input  logic [bierrep_pkg::HALF_W-1:0] addr_lo,
	input  logic [bierrep_pkg::HALF_W-1:0] mask_hi,
	input  logic [bierrep_pkg::HALF_W-1:0] mask_lo,
	input  logic entry_valid,
	input  logic [bierrep_pkg::HOP_W-1:0] hop_count,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] kind,
	output logic [bierrep_pkg::ENTRY_IDX_W-1:0] egress_entry,
	output logic [bierrep_pkg::HALF_W-1:0] new_addr_hi,
	output logic [bierrep_pkg::HALF_W-1:0] new_addr_lo,
	output logic [bierrep_pkg::HOP_W-1:0] new_hop_limit,
	output logic last
);
	import bierrep_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	res_t res;

	bierrep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.hop_count(hop_count),
		.sts      (sts),
		.cmd      (cmd)
	);

	bierrep_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.entry_index(entry_index),
		.addr_hi    (addr_hi),
		.addr_lo    (addr_lo),
		.mask_hi    (mask_hi),
		.mask_lo    (mask_lo),
		.entry_valid(entry_valid),
		.hop_count  (hop_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (res)
	);

	assign kind = res.kind;
	assign egress_entry = res.egress;
	assign new_addr_hi = res.addr_hi;
	assign new_addr_lo = res.addr_lo;
	assign new_hop_limit = res.hop;
	assign last = res.last;

`include "bier_ipv6_replicator_unit_defines.svh"

	`BIERREP_ASSERT_IMPL(a_single_is_last, out_valid && (kind != KIND_REPLICA), last, "non-replica word without last")
	`BIERREP_ASSERT_NEXT(a_pkt_blocks_input, in_valid && in_ready && (mode == MODE_FWD), !in_ready, "input open after packet accept")
	`BIERREP_ASSERT_IMPL(a_stall_on_full, sts.stall, out_valid && !out_ready, "scan stalled with output free")

endmodule

// ===== sv/bierrep_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BIER IPv6 replicator controller
// Takes words, sequences the table scan and closes each packet.
// ----------------------------------------------------------------------------
module bierrep_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [bierrep_pkg::HOP_W-1:0] hop_count,
	input  bierrep_pkg::dp_sts_t sts,
	output bierrep_pkg::dp_cmd_t cmd
);
	import bierrep_pkg::*;

	state_t state_q, state_nxt;
	logic [CNT_W-1:0] iss_q;
	logic done;
	logic hop_low;

	assign done = (iss_q == CNT_W'(TABLE_ENTRIES));
	assign hop_low = (hop_count < HOP_MIN_FWD);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && mode == MODE_FWD) begin
					state_nxt = hop_low ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (done && (!sts.s1_vld || !sts.stall)) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		cmd.idx = iss_q[IDX_W-1:0];
		cmd.hop_exc = hop_low;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.wr = in_valid && (mode == MODE_WRITE);
				cmd.load = in_valid && (mode == MODE_FWD);
			end
			ST_SCAN: begin
				cmd.issue = !done && !sts.stall;
			end
			ST_DRAIN: begin
				cmd.final_res = sts.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				iss_q <= '0;
			end else if (cmd.issue) begin
				iss_q <= iss_q + CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/bierrep_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BIER IPv6 replicator datapath
// Entry table, match stage taking one entry a cycle unless stalled, pending
// replica and the output word register.
// ----------------------------------------------------------------------------
module bierrep_dp (
	input  logic clk,
	input  logic arst_n,
	input  bierrep_pkg::dp_cmd_t cmd,
	output bierrep_pkg::dp_sts_t sts,
	input  logic [bierrep_pkg::ENTRY_IDX_W-1:0] entry_index,
	input  logic [bierrep_pkg::HALF_W-1:0] addr_hi,
	input  logic [bierrep_pkg::HALF_W-1:0] addr_lo,
	input  logic [bierrep_pkg::HALF_W-1:0] mask_hi,
	input  logic [bierrep_pkg::HALF_W-1:0] mask_lo,
	input  logic entry_valid,
	input  logic [bierrep_pkg::HOP_W-1:0] hop_count,
	output logic out_valid,
	input  logic out_ready,
	output bierrep_pkg::res_t out_res
);
	import bierrep_pkg::*;

	entry_t mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] used_q;

	logic [HALF_W-1:0] dst_hi_q, dst_lo_q;
	logic [HOP_W-1:0] nhop_q;

	entry_t rd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic used_s1;
	logic vld_s1;

	res_t pend_q;
	logic pend_vld_q;
	res_t out_q;
	logic out_vld_q;

	logic [HALF_W-1:0] d_hi, d_lo;
	logic match, resid, hit, stall, out_free, take;
	logic out_load;
	res_t out_nxt;
	res_t rep;
	res_t hop_res;

	assign d_hi = dst_hi_q & rd_s1.addr_hi;
	assign d_lo = dst_lo_q & rd_s1.addr_lo;
	assign match = (((dst_hi_q ^ rd_s1.addr_hi) & rd_s1.mask_hi) == '0) &&
		(((dst_lo_q ^ rd_s1.addr_lo) & rd_s1.mask_lo) == '0);
	assign resid = ((d_hi & ~rd_s1.mask_hi) != '0) || ((d_lo & ~rd_s1.mask_lo) != '0);
	assign hit = vld_s1 && used_s1 && match && resid;
	assign out_free = !out_vld_q || out_ready;
	assign stall = hit && pend_vld_q && !out_free;
	assign take = hit && !stall;

	assign sts.s1_vld = vld_s1;
	assign sts.stall = stall;
	assign sts.out_free = out_free;

	always_comb begin
		rep.kind = KIND_REPLICA;
		rep.egress = ENTRY_IDX_W'(idx_s1);
		rep.addr_hi = d_hi;
		rep.addr_lo = d_lo;
		rep.hop = nhop_q;
		rep.last = 1'b0;
	end

	always_comb begin
		hop_res = '0;
		hop_res.kind = KIND_HOP_EXCEEDED;
		hop_res.last = 1'b1;
	end

	always_comb begin
		out_load = 1'b0;
		out_nxt = pend_q;
		if (cmd.final_res) begin
			out_load = 1'b1;
			if (!pend_vld_q) begin
				out_nxt = '0;
				out_nxt.kind = KIND_NO_REPLICA;
			end
			out_nxt.last = 1'b1;
		end else if (take && pend_vld_q) begin
			out_load = 1'b1;
			out_nxt.last = 1'b0;
		end
	end

	// table store and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr && (entry_index < TABLE_ENTRIES)) begin
			mem[IDX_W'(entry_index)] <= '{addr_hi, addr_lo, mask_hi, mask_lo};
		end
		if (cmd.issue) begin
			rd_s1 <= mem[cmd.idx];
			idx_s1 <= cmd.idx;
			used_s1 <= used_q[cmd.idx];
		end
		if (cmd.load) begin
			dst_hi_q <= addr_hi;
			dst_lo_q <= addr_lo;
			nhop_q <= hop_count - HOP_W'(1);
		end
		if (cmd.load) begin
			pend_q <= hop_res;
		end else if (take) begin
			pend_q <= rep;
		end
		if (out_load) begin
			out_q <= out_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			vld_s1 <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.wr && (entry_index < TABLE_ENTRIES)) begin
				used_q[IDX_W'(entry_index)] <= entry_valid;
			end
			if (!stall) begin
				vld_s1 <= cmd.issue;
			end
			if (cmd.load) begin
				pend_vld_q <= cmd.hop_exc;
			end else if (take) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.final_res) begin
				pend_vld_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_res = out_q;

endmodule

// ===== tb/sv/tb_bier_ipv6_replicator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BIER IPv6 replicator testbench
// Loads table slots and forwards packets through the replicator with random
// idling on both channels. A scoreboard keeps its own copy of the table,
// predicts the replica, hop-limit and no-replica words of every packet, and
// compares each output word with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bier_ipv6_replicator_unit;
	import bierrep_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SLOTS = 16;

	typedef struct {
		kind_t rkind;
		logic [ENTRY_IDX_W-1:0] egress;
		logic [HALF_W-1:0] addr_hi;
		logic [HALF_W-1:0] addr_lo;
		logic [HOP_W-1:0] hop;
		logic last;
	} fwd_word_t;

	class replica_scoreboard;
		logic [127:0] slot_addr [SLOTS];
		logic [127:0] slot_mask [SLOTS];
		bit slot_used [SLOTS];
		fwd_word_t pending_q [$];
		int errors;

		function void clear_table();
			for (int i = 0; i < SLOTS; i++) begin
				slot_addr[i] = '0;
				slot_mask[i] = '0;
				slot_used[i] = 1'b0;
			end
			errors = 0;
		endfunction

		function void push_word(kind_t k, int eg, logic [127:0] d, logic [HOP_W-1:0] hop,
				logic lst);
			fwd_word_t w;
			w.rkind = k;
			w.egress = eg[ENTRY_IDX_W-1:0];
			w.addr_hi = d[127:64];
			w.addr_lo = d[63:0];
			w.hop = hop;
			w.last = lst;
			pending_q.push_back(w);
		endfunction

		// update the table on a write, predict the replicas of a packet
		function void note_word(logic md, logic [ENTRY_IDX_W-1:0] idx, logic [127:0] a,
				logic [127:0] msk, logic ev, logic [HOP_W-1:0] hop);
			logic [127:0] d;
			int n;
			if (md == MODE_WRITE) begin
				slot_addr[idx] = a;
				slot_mask[idx] = msk;
				slot_used[idx] = ev;
				return;
			end
			if (hop <= 8'd1) begin
				push_word(KIND_HOP_EXCEEDED, 0, '0, '0, 1'b1);
				return;
			end
			n = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_used[i] && ((a ^ slot_addr[i]) & slot_mask[i]) == '0) begin
					d = a & slot_addr[i];
					if ((d & ~slot_mask[i]) != '0) begin
						push_word(KIND_REPLICA, i, d, hop - 8'd1, 1'b0);
						n++;
					end
				end
			end
			if (n == 0)
				push_word(KIND_NO_REPLICA, 0, '0, '0, 1'b1);
			else
				pending_q[pending_q.size() - 1].last = 1'b1;
		endfunction

		function void check_word(logic [1:0] k, logic [ENTRY_IDX_W-1:0] eg,
				logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo, logic [HOP_W-1:0] hop,
				logic lst);
			fwd_word_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected output word: kind %0d egress %0d", k, eg);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (k !== e.rkind) begin
				$error("kind: expected %0d, got %0d", e.rkind, k);
				errors++;
			end
			if (eg !== e.egress) begin
				$error("egress_entry: expected %0d, got %0d", e.egress, eg);
				errors++;
			end
			if (hi !== e.addr_hi) begin
				$error("new_addr_hi: expected %h, got %h", e.addr_hi, hi);
				errors++;
			end
			if (lo !== e.addr_lo) begin
				$error("new_addr_lo: expected %h, got %h", e.addr_lo, lo);
				errors++;
			end
			if (hop !== e.hop) begin
				$error("new_hop_limit: expected %0d, got %0d", e.hop, hop);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, lst);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic mode;
	logic [ENTRY_IDX_W-1:0] entry_index;
	logic [HALF_W-1:0] addr_hi;
	logic [HALF_W-1:0] addr_lo;
	logic [HALF_W-1:0] mask_hi;
	logic [HALF_W-1:0] mask_lo;
	logic entry_valid;
	logic [HOP_W-1:0] hop_count;
	logic out_valid;
	logic out_ready;
	logic [1:0] kind;
	logic [ENTRY_IDX_W-1:0] egress_entry;
	logic [HALF_W-1:0] new_addr_hi;
	logic [HALF_W-1:0] new_addr_lo;
	logic [HOP_W-1:0] new_hop_limit;
	logic last;

	replica_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int cycles;

	bier_ipv6_replicator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.entry_index(entry_index),
		.addr_hi(addr_hi),
		.addr_lo(addr_lo),
		.mask_hi(mask_hi),
		.mask_lo(mask_lo),
		.entry_valid(entry_valid),
		.hop_count(hop_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.egress_entry(egress_entry),
		.new_addr_hi(new_addr_hi),
		.new_addr_lo(new_addr_lo),
		.new_hop_limit(new_hop_limit),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		mode = MODE_WRITE;
		entry_index = '0;
		addr_hi = '0;
		addr_lo = '0;
		mask_hi = '0;
		mask_lo = '0;
		entry_valid = 1'b0;
		hop_count = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cycles = 0;
	end

	always #10 clk = ~clk;

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(kind, egress_entry, new_addr_hi, new_addr_lo, new_hop_limit, last);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_bier_ipv6_replicator_unit: errors");
			$finish;
		end
	end

	function automatic logic [127:0] rand_addr();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic [127:0] prefix_mask(int len);
		return ~128'd0 << (128 - len);
	endfunction

	function automatic logic [HOP_W-1:0] pick_hop();
		int sel;
		sel = $urandom_range(99);
		if (sel < 4)
			return 8'd0;
		if (sel < 8)
			return 8'd1;
		if (sel < 11)
			return 8'd2;
		if (sel < 14)
			return 8'd255;
		return HOP_W'($urandom_range(2, 255));
	endfunction

	task automatic send_word(logic md, logic [ENTRY_IDX_W-1:0] idx, logic [127:0] a,
			logic [127:0] msk, logic ev, logic [HOP_W-1:0] hop);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode = md;
		entry_index = idx;
		addr_hi = a[127:64];
		addr_lo = a[63:0];
		mask_hi = msk[127:64];
		mask_lo = msk[63:0];
		entry_valid = ev;
		hop_count = hop;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_word(md, idx, a, msk, ev, hop);
	endtask

	task automatic send_packet(logic [127:0] dst, logic [HOP_W-1:0] hop);
		send_word(MODE_FWD, ENTRY_IDX_W'($urandom), dst, rand_addr(), 1'($urandom), hop);
	endtask

	// hold the input until every predicted word has come out
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int quota);
		logic [127:0] msk;
		logic [127:0] pfx;
		logic [127:0] bits;
		int sent;
		int nw;
		int np;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(99) < 80) begin
				msk = prefix_mask($urandom_range(0, 128));
				pfx = rand_addr() & msk;
				nw = $urandom_range(1, 6);
				np = $urandom_range(1, 4);
				for (int i = 0; i < nw; i++) begin
					bits = $urandom_range(1) ? rand_addr() : (128'd1 << $urandom_range(127));
					send_word(MODE_WRITE, ENTRY_IDX_W'($urandom), pfx | (bits & ~msk), msk,
						$urandom_range(99) < 90, HOP_W'($urandom));
				end
				for (int i = 0; i < np; i++)
					send_packet(pfx | (rand_addr() & ~msk), pick_hop());
				sent += nw + np;
			end else begin
				case ($urandom_range(2))
					0: send_word(MODE_WRITE, ENTRY_IDX_W'($urandom), rand_addr(), rand_addr(),
						1'($urandom), HOP_W'($urandom));
					1: send_packet(rand_addr(), pick_hop());
					default: send_packet(rand_addr(), HOP_W'($urandom_range(1)));
				endcase
				sent++;
			end
		end
	endtask

	initial begin
		sb = new;
		sb.clear_table();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table, then hop limits at and below the floor
		send_packet(rand_addr(), 8'd64);
		send_packet(rand_addr(), 8'd0);
		send_packet(rand_addr(), 8'd1);
		// every slot unmasked with all bits set: full fan-out
		for (int i = 0; i < SLOTS; i++)
			send_word(MODE_WRITE, ENTRY_IDX_W'(i), ~128'd0, '0, 1'b1, 8'd0);
		send_packet(~128'd0, 8'd2);
		send_packet('0, 8'd255);
		// remove one slot, mask another completely
		send_word(MODE_WRITE, 4'd5, ~128'd0, ~128'd0, 1'b0, 8'd255);
		send_word(MODE_WRITE, 4'd7, ~128'd0, ~128'd0, 1'b1, 8'd255);
		send_packet(~128'd0, 8'd255);
		send_packet(~128'd0, 8'd1);
		drain_results();

		run_phase(0, 0, 85);
		drain_results();
		run_phase(47, 0, 85);
		run_phase(0, 47, 85);
		drain_results();
		run_phase(28, 28, 85);

		drain_results();
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_bier_ipv6_replicator_unit: clean");
		else
			$display("tb_bier_ipv6_replicator_unit: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bierrep_pkg.sv
sv/bierrep_ctrl.sv
sv/bierrep_dp.sv
sv/bier_ipv6_replicator_unit.sv
tb/sv/tb_bier_ipv6_replicator_unit.sv
